// File: design/pdcm_pkg.sv
// ----------------------------------------------------------------------------
// pdcm_pkg
// Shared types and constants for the PWM duty capture meter.
// ----------------------------------------------------------------------------
package pdcm_pkg;

	localparam int NUM_CHANNELS = 2;
	localparam int CH_W         = 1;
	localparam int TICK_W       = 16;
	localparam int DUTY_W       = TICK_W + 1;
	localparam int SUM_W        = TICK_W + 1;
	localparam int DIV_STEPS    = TICK_W;
	localparam int STEP_W       = $clog2(DIV_STEPS);

	// queue between capture front end and divider
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [1:0] PH_RISE  = 2'd0;
	localparam logic [1:0] PH_FALL  = 2'd1;
	localparam logic [1:0] PH_CLOSE = 2'd2;

	localparam logic [TICK_W-1:0] TOP_RESET = 16'hFFFF;

	// one completed capture cycle, waiting for the duty division
	typedef struct packed {
		logic [CH_W-1:0]   ch;
		logic [TICK_W-1:0] hi;
		logic [TICK_W-1:0] lo;
	} meas_t;

endpackage

// File: design/pdcm_front.sv
// ----------------------------------------------------------------------------
// pdcm_front
// Per-channel edge tracking: phase, last stamp and high time; pushes a
// measurement on every closing rising edge.
// ----------------------------------------------------------------------------
module pdcm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [pdcm_pkg::TICK_W-1:0]   counter_top,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pdcm_pkg::CH_W-1:0]     in_ch,
	input  logic [pdcm_pkg::TICK_W-1:0]   in_time,
	output logic                          push_valid,
	input  logic                          push_ready,
	output pdcm_pkg::meas_t               push_data
);

	logic [1:0]                    phase_q [pdcm_pkg::NUM_CHANNELS];
	logic [pdcm_pkg::TICK_W-1:0]   last_q  [pdcm_pkg::NUM_CHANNELS];
	logic [pdcm_pkg::TICK_W-1:0]   high_q  [pdcm_pkg::NUM_CHANNELS];

	logic                          ch_ok;
	logic                          accept;
	logic [1:0]                    cur_phase;
	logic [pdcm_pkg::TICK_W-1:0]   cur_last;
	logic [pdcm_pkg::TICK_W-1:0]   diff;
	logic [pdcm_pkg::TICK_W-1:0]   period;

	assign ch_ok     = (int'(in_ch) < pdcm_pkg::NUM_CHANNELS);
	assign in_ready  = push_ready;
	assign accept    = in_valid && in_ready && ch_ok;
	assign cur_phase = phase_q[in_ch];
	assign cur_last  = last_q[in_ch];

	// counter period is counter_top+1, taken mod 2^16
	assign period = counter_top + pdcm_pkg::TICK_W'(1);
	assign diff   = (in_time < cur_last) ? (in_time - cur_last + period)
	                                     : (in_time - cur_last);

	assign push_valid   = in_valid && ch_ok && (cur_phase != pdcm_pkg::PH_RISE)
	                      && (cur_phase != pdcm_pkg::PH_FALL);
	assign push_data.ch = in_ch;
	assign push_data.hi = high_q[in_ch];
	assign push_data.lo = diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pdcm_pkg::NUM_CHANNELS; i++) begin
				phase_q[i] <= pdcm_pkg::PH_RISE;
				last_q[i]  <= '0;
				high_q[i]  <= '0;
			end
		end else if (accept) begin
			last_q[in_ch] <= in_time;
			unique case (cur_phase)
				pdcm_pkg::PH_RISE: begin
					phase_q[in_ch] <= pdcm_pkg::PH_FALL;
				end
				pdcm_pkg::PH_FALL: begin
					high_q[in_ch]  <= diff;
					phase_q[in_ch] <= pdcm_pkg::PH_CLOSE;
				end
				default: begin
					phase_q[in_ch] <= pdcm_pkg::PH_RISE;
				end
			endcase
		end
	end

endmodule

// File: design/pdcm_fifo.sv
// ----------------------------------------------------------------------------
// pdcm_fifo
// Short measurement queue between the capture front end and the divider.
// ----------------------------------------------------------------------------
module pdcm_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  pdcm_pkg::meas_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output pdcm_pkg::meas_t pop_data
);

	pdcm_pkg::meas_t                mem_q [pdcm_pkg::Q_DEPTH];
	logic [pdcm_pkg::Q_PTR_W-1:0]   wr_ptr_q;
	logic [pdcm_pkg::Q_PTR_W-1:0]   rd_ptr_q;
	logic [pdcm_pkg::Q_CNT_W-1:0]   count_q;
	logic                           do_push;
	logic                           do_pop;

	assign push_ready = (count_q != pdcm_pkg::Q_CNT_W'(pdcm_pkg::Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == pdcm_pkg::Q_DEPTH - 1) ? '0
				            : wr_ptr_q + pdcm_pkg::Q_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == pdcm_pkg::Q_DEPTH - 1) ? '0
				            : rd_ptr_q + pdcm_pkg::Q_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + pdcm_pkg::Q_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - pdcm_pkg::Q_CNT_W'(1);
			end
		end
	end

endmodule

// File: design/pdcm_back.sv
// ----------------------------------------------------------------------------
// pdcm_back
// Serial restoring divider for duty = high*65536/(high+low), with the
// output register.
// ----------------------------------------------------------------------------
module pdcm_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pop_valid,
	output logic                          pop_ready,
	input  pdcm_pkg::meas_t               pop_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pdcm_pkg::CH_W-1:0]     out_ch,
	output logic [pdcm_pkg::TICK_W-1:0]   out_hi,
	output logic [pdcm_pkg::TICK_W-1:0]   out_lo,
	output logic [pdcm_pkg::DUTY_W-1:0]   out_duty,
	output logic                          out_zero
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                         state_q;
	pdcm_pkg::meas_t                meas_q;
	logic [pdcm_pkg::SUM_W-1:0]     sum_q;
	logic [pdcm_pkg::SUM_W-1:0]     rem_q;
	logic [pdcm_pkg::DUTY_W-1:0]    quo_q;
	logic [pdcm_pkg::STEP_W-1:0]    step_q;
	logic                           zero_q;

	logic                           o_valid_q;
	logic [pdcm_pkg::CH_W-1:0]      o_ch_q;
	logic [pdcm_pkg::TICK_W-1:0]    o_hi_q;
	logic [pdcm_pkg::TICK_W-1:0]    o_lo_q;
	logic [pdcm_pkg::DUTY_W-1:0]    o_duty_q;
	logic                           o_zero_q;

	logic [pdcm_pkg::SUM_W-1:0]     new_sum;
	logic [pdcm_pkg::SUM_W:0]       rem_sh;
	logic                           q_bit;
	logic [pdcm_pkg::SUM_W-1:0]     rem_next;
	logic                           out_free;

	assign pop_ready = (state_q == ST_IDLE);
	assign out_free  = !o_valid_q || out_ready;
	assign new_sum   = {1'b0, pop_data.hi} + {1'b0, pop_data.lo};

	assign rem_sh   = {rem_q, 1'b0};
	assign q_bit    = (rem_sh >= {1'b0, sum_q});
	assign rem_next = q_bit ? pdcm_pkg::SUM_W'(rem_sh - {1'b0, sum_q})
	                        : pdcm_pkg::SUM_W'(rem_sh);

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					meas_q <= pop_data;
					sum_q  <= new_sum;
					step_q <= '0;
					zero_q <= (new_sum == '0);
					// integer part is 1 only when low is zero
					if (pop_data.lo == '0) begin
						quo_q <= pdcm_pkg::DUTY_W'(1);
						rem_q <= '0;
					end else begin
						quo_q <= '0;
						rem_q <= {1'b0, pop_data.hi};
					end
				end
			end
			ST_DIV: begin
				rem_q  <= rem_next;
				quo_q  <= {quo_q[pdcm_pkg::DUTY_W-2:0], q_bit};
				step_q <= step_q + pdcm_pkg::STEP_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			o_valid_q <= 1'b0;
			o_ch_q    <= '0;
			o_hi_q    <= '0;
			o_lo_q    <= '0;
			o_duty_q  <= '0;
			o_zero_q  <= 1'b0;
		end else begin
			// in ST_DONE a taken item is replaced below instead
			if (o_valid_q && out_ready && (state_q != ST_DONE)) begin
				o_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= (new_sum == '0) ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV: begin
					if (int'(step_q) == pdcm_pkg::DIV_STEPS - 1) begin
						state_q <= ST_DONE;
					end
				end
				default: begin
					if (out_free) begin
						o_valid_q <= 1'b1;
						o_ch_q    <= meas_q.ch;
						o_hi_q    <= meas_q.hi;
						o_lo_q    <= meas_q.lo;
						o_duty_q  <= zero_q ? '0 : quo_q;
						o_zero_q  <= zero_q;
						state_q   <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign out_valid = o_valid_q;
	assign out_ch    = o_ch_q;
	assign out_hi    = o_hi_q;
	assign out_lo    = o_lo_q;
	assign out_duty  = o_duty_q;
	assign out_zero  = o_zero_q;

endmodule

// File: design/pwm_duty_capture_meter.sv
// ----------------------------------------------------------------------------
// pwm_duty_capture_meter
// PWM duty meter fed by input-capture timestamps, one edge per item.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes capture edges: tuser = channel, tdata = capture time. Each
//   channel walks rising, falling, rising; the closing edge emits one item
//   on m_* with high and low tick counts and duty in unsigned Q1.16.
//   Differences wrap modulo counter_top+1; cfg_wen/cfg_wdata set
//   counter_top (reset 65535); the user writes it only while the block is
//   idle, which the block itself does not enforce. Edges in the first two
//   phases give no result. A closing edge passes a two-entry queue into a
//   bit-serial divider: one quotient bit per cycle, 16 steps plus load and
//   hand-off to the output register; a zero period skips the steps. The
//   divider takes a new measurement only after handing off the last one.
//   s_tready drops only while the queue is full. A stalled m_tready holds
//   the output register; the divider then waits with its finished result
//   and the queue fills behind it.
//   Reset clears all channel phases, stamps and high times, the queue and
//   the output register.
// ----------------------------------------------------------------------------
module pwm_duty_capture_meter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,   // counter_top
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,     // [15:0] capture_time
	input  logic [0:0]  s_tuser,     // [0] channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,     // [15:0] high_ticks, [31:16] low_ticks,
	                                 // [48:32] duty_q16, [55:49] zero
	output logic [1:0]  m_tuser      // [0] result_channel, [1] zero_period
);

	logic [pdcm_pkg::TICK_W-1:0]   counter_top_q;

	logic                          push_valid;
	logic                          push_ready;
	pdcm_pkg::meas_t               push_data;
	logic                          pop_valid;
	logic                          pop_ready;
	pdcm_pkg::meas_t               pop_data;

	logic [pdcm_pkg::CH_W-1:0]     res_ch;
	logic [pdcm_pkg::TICK_W-1:0]   res_hi;
	logic [pdcm_pkg::TICK_W-1:0]   res_lo;
	logic [pdcm_pkg::DUTY_W-1:0]   res_duty;
	logic                          res_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_top_q <= pdcm_pkg::TOP_RESET;
		end else if (cfg_wen) begin
			counter_top_q <= cfg_wdata;
		end
	end

	pdcm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.counter_top (counter_top_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_ch       (s_tuser),
		.in_time     (s_tdata),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	pdcm_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	pdcm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_ch    (res_ch),
		.out_hi    (res_hi),
		.out_lo    (res_lo),
		.out_duty  (res_duty),
		.out_zero  (res_zero)
	);

	assign m_tdata = {7'd0, res_duty, res_lo, res_hi};
	assign m_tuser = {res_zero, res_ch};

`ifndef SYNTH
	// a zero period always reports zero duty
	a_zero_duty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[48:32] == 17'd0)
		else $error("zero period with nonzero duty");

	// duty never exceeds 100 percent
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[48:32] <= 17'h10000)
		else $error("duty above full scale");

	// full duty only when the low time is zero
	a_full_duty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[48:32] == 17'h10000 |-> m_tdata[31:16] == 16'd0)
		else $error("full duty with nonzero low time");
`endif

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PWM duty capture meter: capture edges go in
// on the s_ stream, duty measurements are scored on the m_ stream against
// an in-bench model of the per-channel rise, fall, rise walk and the Q1.16 divide.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int LIMIT_CYCLES = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 150;

	typedef struct packed {
		logic [pdcm_pkg::CH_W-1:0]   ch;
		logic [pdcm_pkg::TICK_W-1:0] stamp;
	} capture_t;

	typedef struct packed {
		logic [pdcm_pkg::CH_W-1:0]   ch;
		logic [pdcm_pkg::TICK_W-1:0] hi;
		logic [pdcm_pkg::TICK_W-1:0] lo;
		logic [pdcm_pkg::DUTY_W-1:0] duty;
		logic                        zp;
	} duty_meas_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;      // [15:0] capture_time
	logic [0:0]  s_tuser = '0;      // [0] channel
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;           // [15:0] high, [31:16] low, [48:32] duty
	logic [1:0]  m_tuser;           // [0] channel, [1] zero_period

	// stimulus side
	capture_t   capture_q[$];
	int         issued_cnt = 0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	bit         hold_arm = 1'b0;
	bit         hold_done = 1'b0;
	int         hold_left = 0;
	int         gen_top = 65535;
	int         gen_prev[pdcm_pkg::NUM_CHANNELS];

	// scoreboard side
	duty_meas_t pending_duty_q[$];
	int         accepted_cnt = 0;
	int         err_cnt = 0;
	int         cyc = 0;
	logic       in_taken = 1'b0;
	logic [1:0]                  chan_phase[pdcm_pkg::NUM_CHANNELS];
	logic [pdcm_pkg::TICK_W-1:0] chan_last[pdcm_pkg::NUM_CHANNELS];
	logic [pdcm_pkg::TICK_W-1:0] chan_high[pdcm_pkg::NUM_CHANNELS];
	logic [pdcm_pkg::TICK_W-1:0] meter_top = pdcm_pkg::TOP_RESET;

	pwm_duty_capture_meter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #4 clk = ~clk;

	// ticks from earlier to later stamp, wrapping at top+1
	function automatic logic [pdcm_pkg::TICK_W-1:0] tick_span(
			input logic [pdcm_pkg::TICK_W-1:0] earlier,
			input logic [pdcm_pkg::TICK_W-1:0] later,
			input logic [pdcm_pkg::TICK_W-1:0] top);
		logic [31:0] d;
		d = {16'b0, later} - {16'b0, earlier};
		if (later < earlier)
			d = d + {16'b0, top} + 32'd1;
		return d[pdcm_pkg::TICK_W-1:0];
	endfunction

	task automatic advance_channel(input logic [pdcm_pkg::CH_W-1:0] ch,
			input logic [pdcm_pkg::TICK_W-1:0] t);
		duty_meas_t m;
		logic [pdcm_pkg::SUM_W-1:0] sum;
		logic [32:0] quo;
		case (chan_phase[ch])
			pdcm_pkg::PH_RISE: begin
				chan_last[ch] = t;
				chan_phase[ch] = pdcm_pkg::PH_FALL;
			end
			pdcm_pkg::PH_FALL: begin
				chan_high[ch] = tick_span(chan_last[ch], t, meter_top);
				chan_last[ch] = t;
				chan_phase[ch] = pdcm_pkg::PH_CLOSE;
			end
			default: begin
				// closing rising edge; the unused phase code lands here too
				m.ch = ch;
				m.hi = chan_high[ch];
				m.lo = tick_span(chan_last[ch], t, meter_top);
				chan_last[ch] = t;
				chan_phase[ch] = pdcm_pkg::PH_RISE;
				sum = {1'b0, m.hi} + {1'b0, m.lo};
				if (sum == '0) begin
					m.duty = '0;
					m.zp = 1'b1;
				end else begin
					quo = {1'b0, m.hi, 16'b0} / {16'b0, sum};
					m.duty = quo[pdcm_pkg::DUTY_W-1:0];
					m.zp = 1'b0;
				end
				pending_duty_q.push_back(m);
			end
		endcase
	endtask

	// input side: prediction at acceptance; output side: scoring
	always @(posedge clk) begin : score_p
		duty_meas_t got;
		duty_meas_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= s_tvalid && s_tready;
			if (cfg_wen)
				meter_top = cfg_wdata;
			if (s_tvalid && s_tready) begin
				advance_channel(s_tuser, s_tdata);
				accepted_cnt++;
			end
			if (m_tvalid && m_tready) begin
				got.ch = m_tuser[0];
				got.zp = m_tuser[1];
				got.hi = m_tdata[15:0];
				got.lo = m_tdata[31:16];
				got.duty = m_tdata[48:32];
				if (pending_duty_q.size() == 0) begin
					$display("%0t: unexpected item ch=%0d hi=%0d lo=%0d duty=%0d zp=%0d",
						$time, got.ch, got.hi, got.lo, got.duty, got.zp);
					err_cnt++;
				end else begin
					want = pending_duty_q.pop_front();
					if (got.ch !== want.ch) begin
						$display("%0t: channel expected %0d got %0d", $time, want.ch, got.ch);
						err_cnt++;
					end
					if (got.hi !== want.hi) begin
						$display("%0t: high_ticks expected %0d got %0d", $time, want.hi, got.hi);
						err_cnt++;
					end
					if (got.lo !== want.lo) begin
						$display("%0t: low_ticks expected %0d got %0d", $time, want.lo, got.lo);
						err_cnt++;
					end
					if (got.duty !== want.duty) begin
						$display("%0t: duty_q16 expected %0d got %0d", $time, want.duty,
							got.duty);
						err_cnt++;
					end
					if (got.zp !== want.zp) begin
						$display("%0t: zero_period expected %0d got %0d", $time, want.zp,
							got.zp);
						err_cnt++;
					end
				end
			end
		end
	end

	always @(negedge clk) begin : drive_p
		capture_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_taken) begin
			if (capture_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = capture_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= nxt.stamp;
				s_tuser <= nxt.ch;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_arm && !hold_done) begin
			// long back-pressure so the queue fills and s_tready drops
			m_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic push_capture(input logic [pdcm_pkg::CH_W-1:0] ch,
			input logic [pdcm_pkg::TICK_W-1:0] stamp);
		capture_t c;
		c.ch = ch;
		c.stamp = stamp;
		capture_q.push_back(c);
		issued_cnt++;
	endtask

	task automatic queue_random_captures(input int count);
		int period;
		int step;
		int ch;
		period = gen_top + 1;
		for (int i = 0; i < count; i++) begin
			ch = $urandom_range(pdcm_pkg::NUM_CHANNELS - 1);
			if ($urandom_range(9) == 0) begin
				// noise: any 16-bit stamp, which can lie above counter_top
				gen_prev[ch] = $urandom_range(16'hFFFF);
			end else begin
				case ($urandom_range(3))
					0: step = $urandom_range(3);
					1: step = $urandom_range(gen_top);
					2: step = gen_top - $urandom_range(gen_top < 3 ? gen_top : 3);
					default: step = $urandom_range(gen_top / 8);
				endcase
				gen_prev[ch] = (gen_prev[ch] % period + step) % period;
			end
			push_capture(ch[pdcm_pkg::CH_W-1:0], gen_prev[ch][pdcm_pkg::TICK_W-1:0]);
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (accepted_cnt != issued_cnt || pending_duty_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_counter_top(input logic [15:0] top);
		cfg_wen <= 1'b1;
		cfg_wdata <= top;
		@(negedge clk);
		cfg_wen <= 1'b0;
		gen_top = top;
	endtask

	task automatic run_phase(input logic [15:0] top, input int idle_pct, input int stall_pct,
			input bit with_hold);
		wait_idle();
		set_counter_top(top);
		@(posedge clk);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		hold_arm = with_hold;
		queue_random_captures(PHASE_ITEMS);
	endtask

	initial begin
		for (int c = 0; c < pdcm_pkg::NUM_CHANNELS; c++) begin
			chan_phase[c] = pdcm_pkg::PH_RISE;
			chan_last[c] = '0;
			chan_high[c] = '0;
			gen_prev[c] = 0;
		end
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset counter_top
		push_capture(1'b0, 16'd0);     // zero period
		push_capture(1'b0, 16'd0);
		push_capture(1'b0, 16'd0);
		push_capture(1'b1, 16'd100);   // no low time, full duty
		push_capture(1'b1, 16'd300);
		push_capture(1'b1, 16'd300);
		push_capture(1'b0, 16'hFFFF);  // wrap on the falling edge
		push_capture(1'b0, 16'h0000);
		push_capture(1'b0, 16'hFFFF);
		push_capture(1'b1, 16'h0000);  // largest high time
		push_capture(1'b1, 16'hFFFF);
		push_capture(1'b1, 16'hFFFF);
		push_capture(1'b1, 16'h0000);  // both counts at max, sum needs 17 bits
		push_capture(1'b1, 16'hFFFF);
		push_capture(1'b1, 16'hFFFE);
		push_capture(1'b0, 16'd10);    // channels interleaved
		push_capture(1'b1, 16'd20);
		push_capture(1'b0, 16'd30);
		push_capture(1'b1, 16'd50);
		push_capture(1'b1, 16'd90);
		push_capture(1'b0, 16'd70);

		run_phase(16'hFFFF, 0, 0, 1'b0);
		run_phase(16'd1, 60, 0, 1'b0);
		run_phase(16'd0, 0, 60, 1'b0);  // period of one tick
		run_phase(16'd1000, 15, 15, 1'b0);
		run_phase(16'd255, 0, 0, 1'b1);
		run_phase(16'($urandom_range(2, 65534)), 60, 0, 1'b0);
		run_phase(16'd40000, 0, 60, 1'b0);
		run_phase(16'hFFFF, 15, 15, 1'b0);
		run_phase(16'($urandom_range(2, 65534)), 0, 0, 1'b0);

		wait_idle();
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: filelist.f
design/pdcm_pkg.sv
design/pdcm_front.sv
design/pdcm_fifo.sv
design/pdcm_back.sv
design/pwm_duty_capture_meter.sv
tb/sv/tb_top.sv
